// File: src/assert_macros.svh
// Assertion macros used by the RTL file poly_voice_allocator.sv of the voice allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication assertion failed");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

// The condition must never be true.
`define ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`define ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

// File: src/pva_pkg.sv
// Types, constants and helper functions of the polyphonic voice allocator.
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

  // Voice pool size, result limit and the widths that follow from them.
  localparam int VOICES      = 8;
  localparam int VIDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W       = $clog2(VOICES + 1);
  localparam int MAX_RESULTS = 8;
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

  // Command codes of an input event.
  localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd1;

  // Action codes of a result.
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Register index decoded from the APB word address.
  localparam logic REG_POLY_MODE = 1'b0;

  // Lowest note of the pitch table.
  localparam logic [6:0] LOW_NOTE = 7'd24;

  // One input event.
  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] velocity;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic       action;
    logic [2:0] voice;
    logic [6:0] note_out;
    logic [6:0] freq_index;
    logic [4:0] level;
    logic       last;
  } out_item_t;

  // Operations the voice table carries out.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_POLY_START,
    OP_POLY_RELEASE,
    OP_CHAN_START,
    OP_CHAN_RELEASE
  } vt_op_t;

  // Sequencer to voice table.
  typedef struct packed {
    vt_op_t            op;
    logic [VIDX_W-1:0] idx;
    logic [6:0]        note;
  } vt_ctrl_t;

  // Voice table to sequencer.
  typedef struct packed {
    logic              match;
    logic [VIDX_W-1:0] head_voice;
    logic [CNT_W-1:0]  count;
  } vt_stat_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FLUSH
  } pva_state_t;

  // Ring position after p, wrapping at the pool size.
  function automatic logic [VIDX_W-1:0] next_pos(input logic [VIDX_W-1:0] p);
    next_pos = (p == VIDX_W'(VOICES - 1)) ? '0 : p + 1'b1;
  endfunction

  // Start result for a voice.
  function automatic out_item_t make_start(input logic [VIDX_W-1:0] v,
                                           input logic [6:0] note,
                                           input logic [6:0] vel);
    out_item_t r;
    r.action     = ACT_START;
    r.voice      = 3'(v);
    r.note_out   = note;
    r.freq_index = (note >= LOW_NOTE) ? note - LOW_NOTE : note;
    r.level      = vel[6:2];
    r.last       = 1'b1;
    make_start   = r;
  endfunction

  // Release result for a voice.
  function automatic out_item_t make_release(input logic [VIDX_W-1:0] v,
                                             input logic [6:0] note,
                                             input logic last);
    out_item_t r;
    r.action     = ACT_RELEASE;
    r.voice      = 3'(v);
    r.note_out   = note;
    r.freq_index = '0;
    r.level      = '0;
    r.last       = last;
    make_release = r;
  endfunction

endpackage

`default_nettype wire

// File: src/pva_voices.sv
// Voice table: per-voice note and busy state, the free-voice ring and the shared note comparator.
`timescale 1ns / 1ps
`default_nettype none

module pva_voices (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pva_pkg::vt_ctrl_t ctrl,
  output pva_pkg::vt_stat_t    stat
);

  logic [pva_pkg::VIDX_W-1:0] free_ring [pva_pkg::VOICES];
  logic [pva_pkg::VIDX_W-1:0] ring_head;
  logic [pva_pkg::VIDX_W-1:0] ring_tail;
  logic [pva_pkg::CNT_W-1:0]  busy_count;
  logic [6:0]                 voice_note [pva_pkg::VOICES];
  logic [pva_pkg::VOICES-1:0] voice_busy;
  logic [pva_pkg::VIDX_W-1:0] head_voice;

  // The one comparator: does the selected voice sound the requested note?
  always_comb begin
    head_voice      = free_ring[ring_head];
    stat.match      = voice_busy[ctrl.idx] && (voice_note[ctrl.idx] == ctrl.note);
    stat.head_voice = head_voice;
    stat.count      = busy_count;
  end

  // Apply one table operation per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pva_pkg::VOICES; i++) begin
        free_ring[i]  <= pva_pkg::VIDX_W'(i);
        voice_note[i] <= '0;
      end
      voice_busy <= '0;
      ring_head  <= '0;
      ring_tail  <= '0;
      busy_count <= '0;
    end else begin
      case (ctrl.op)
        pva_pkg::OP_POLY_START: begin
          // Take the voice at the head; when all voices sound, the oldest is stolen.
          ring_head <= pva_pkg::next_pos(ring_head);
          if (busy_count >= pva_pkg::CNT_W'(pva_pkg::VOICES)) begin
            ring_tail <= pva_pkg::next_pos(ring_tail);
          end else begin
            busy_count <= busy_count + 1'b1;
          end
          voice_note[head_voice] <= ctrl.note;
          voice_busy[head_voice] <= 1'b1;
        end
        pva_pkg::OP_POLY_RELEASE: begin
          // Free the voice and return it to the tail of the ring.
          voice_busy[ctrl.idx] <= 1'b0;
          voice_note[ctrl.idx] <= '0;
          free_ring[ring_tail] <= ctrl.idx;
          ring_tail            <= pva_pkg::next_pos(ring_tail);
          if (busy_count != '0) begin
            busy_count <= busy_count - 1'b1;
          end
        end
        pva_pkg::OP_CHAN_START: begin
          voice_note[ctrl.idx] <= ctrl.note;
          voice_busy[ctrl.idx] <= 1'b1;
        end
        pva_pkg::OP_CHAN_RELEASE: begin
          voice_busy[ctrl.idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/poly_voice_allocator.sv
// A note-on or channel-mode event is handled in ST_DECODE, and its result is registered from there.
// A poly note-off steps the shared note comparator over all voices, one voice a
// cycle, and keeps busy high through ST_DECODE, ST_SCAN and ST_FLUSH.
// Ignored events pass through ST_DECODE and give no result; results leave one a cycle.
// Synchronous reset clears every voice, refills the ring in order and sets poly mode.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module poly_voice_allocator (
  input  wire logic              clk,
  input  wire logic              rst,
  // Event channel
  input  wire logic              start,
  input  wire pva_pkg::in_item_t item,
  output logic                   busy,
  // Result channel
  output logic                   result_valid,
  output pva_pkg::out_item_t     result,
  // APB configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  pva_pkg::pva_state_t         state, state_next;
  pva_pkg::in_item_t           item_q;
  pva_pkg::vt_ctrl_t           ctrl;
  pva_pkg::vt_stat_t           stat;
  logic                        poly_mode;
  logic [pva_pkg::VIDX_W-1:0]  scan_idx, scan_idx_next;
  logic                        pend_valid, pend_valid_next;
  logic [pva_pkg::VIDX_W-1:0]  pend_voice, pend_voice_next;
  logic [pva_pkg::RCNT_W-1:0]  rep_cnt, rep_cnt_next;
  logic                        emit;
  pva_pkg::out_item_t          emit_item;
  logic                        is_on, is_off, chan_ok;
  logic [pva_pkg::VIDX_W-1:0]  chan_idx;

  assign busy   = (state != pva_pkg::ST_IDLE);
  assign pready = 1'b1;

  // Configuration register write and read back.
  always_ff @(posedge clk) begin
    if (rst) begin
      poly_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == pva_pkg::REG_POLY_MODE)) begin
      poly_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == pva_pkg::REG_POLY_MODE) begin
      prdata = {31'b0, poly_mode};
    end
  end

  // Event decode from the captured item.
  always_comb begin
    is_on    = (item_q.cmd == pva_pkg::CMD_NOTE_ON) && (item_q.velocity != '0);
    is_off   = (item_q.cmd == pva_pkg::CMD_NOTE_OFF) ||
               ((item_q.cmd == pva_pkg::CMD_NOTE_ON) && (item_q.velocity == '0));
    chan_ok  = 32'(item_q.channel) < pva_pkg::VOICES;
    chan_idx = pva_pkg::VIDX_W'(item_q.channel);
  end

  // Voice table with the shared comparator.
  pva_voices u_voices (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat)
  );

  // Sequencer: next state, table operation and result to emit.
  always_comb begin
    state_next      = state;
    scan_idx_next   = scan_idx;
    pend_valid_next = pend_valid;
    pend_voice_next = pend_voice;
    rep_cnt_next    = rep_cnt;
    ctrl.op         = pva_pkg::OP_NONE;
    ctrl.idx        = scan_idx;
    ctrl.note       = item_q.note;
    emit            = 1'b0;
    emit_item       = pva_pkg::make_release(scan_idx, item_q.note, 1'b1);

    case (state)
      pva_pkg::ST_IDLE: begin
        scan_idx_next   = '0;
        pend_valid_next = 1'b0;
        rep_cnt_next    = '0;
        if (start) begin
          state_next = pva_pkg::ST_DECODE;
        end
      end
      pva_pkg::ST_DECODE: begin
        state_next = pva_pkg::ST_IDLE;
        if (poly_mode) begin
          if ((item_q.channel == '0) && is_on) begin
            ctrl.op   = pva_pkg::OP_POLY_START;
            emit      = 1'b1;
            emit_item = pva_pkg::make_start(stat.head_voice, item_q.note, item_q.velocity);
          end else if ((item_q.channel == '0) && is_off) begin
            state_next = pva_pkg::ST_SCAN;
          end
        end else if (chan_ok) begin
          ctrl.idx = chan_idx;
          if (is_on) begin
            ctrl.op   = pva_pkg::OP_CHAN_START;
            emit      = 1'b1;
            emit_item = pva_pkg::make_start(chan_idx, item_q.note, item_q.velocity);
          end else if (is_off && stat.match) begin
            ctrl.op   = pva_pkg::OP_CHAN_RELEASE;
            emit      = 1'b1;
            emit_item = pva_pkg::make_release(chan_idx, item_q.note, 1'b1);
          end
        end
      end
      pva_pkg::ST_SCAN: begin
        // One voice per cycle; the previous match goes out once a later one is found.
        if (stat.match) begin
          ctrl.op = pva_pkg::OP_POLY_RELEASE;
          if (rep_cnt < pva_pkg::RCNT_W'(pva_pkg::MAX_RESULTS)) begin
            if (pend_valid) begin
              emit      = 1'b1;
              emit_item = pva_pkg::make_release(pend_voice, item_q.note, 1'b0);
            end
            pend_valid_next = 1'b1;
            pend_voice_next = scan_idx;
            rep_cnt_next    = rep_cnt + 1'b1;
          end
        end
        if (scan_idx == pva_pkg::VIDX_W'(pva_pkg::VOICES - 1)) begin
          state_next = pva_pkg::ST_FLUSH;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      pva_pkg::ST_FLUSH: begin
        // The held match is the final result of the event.
        state_next = pva_pkg::ST_IDLE;
        if (pend_valid) begin
          emit      = 1'b1;
          emit_item = pva_pkg::make_release(pend_voice, item_q.note, 1'b1);
        end
      end
      default: begin
        state_next = pva_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pva_pkg::ST_IDLE;
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      rep_cnt      <= '0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      pend_valid   <= pend_valid_next;
      rep_cnt      <= rep_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == pva_pkg::ST_IDLE) && start) begin
      item_q <= item;
    end
    scan_idx   <= scan_idx_next;
    pend_voice <= pend_voice_next;
    if (emit) begin
      result <= emit_item;
    end
  end

  // Checks on the sequencer and the voice table.
  `ASSERT_IMPLY(a_result_from_work, clk, rst, result_valid, $past(busy))
  `ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_last_ends_event, clk, rst, result_valid && result.last, !result_valid)
  `ASSERT_NEVER(a_count_in_range, clk, rst, stat.count > pva_pkg::CNT_W'(pva_pkg::VOICES))

endmodule

`default_nettype wire
